>>> design/bsp_pkg.sv
// Shared types and constants for the bencode stream parser.
// No dependencies; imported by bsp_core, bsp_out_buf and bencode_stream_parser.
package bsp_pkg;

    localparam int MAX_DEPTH_DEF = 32;
    localparam int DEPTH_W       = 6;
    localparam int VALUE_W       = 32;
    localparam int BYTE_W        = 8;

    typedef enum logic [3:0] {
        EV_BUSY      = 4'd0,
        EV_STR_START = 4'd1,
        EV_STR_BYTE  = 4'd2,
        EV_INT       = 4'd3,
        EV_LIST      = 4'd4,
        EV_DICT      = 4'd5,
        EV_CLOSE     = 4'd6,
        EV_END       = 4'd7,
        EV_ERROR     = 4'd8
    } t_event;

    typedef struct packed {
        t_event               ev;
        logic [VALUE_W-1:0]   value;
        logic [BYTE_W-1:0]    data_byte;
        logic [DEPTH_W-1:0]   depth;
        logic                 is_key;
        logic                 str_last;
    } t_result;

endpackage

>>> design/bsp_core.sv
// Tokenizer core: parse state, number accumulator, nesting stack and event decode.
// Depends on bsp_pkg.
module bsp_core
    import bsp_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_byte,
    output t_result           o_result
);

    localparam int PTR_W = $clog2(MAX_DEPTH + 1);
    localparam int AW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_E     = 8'h65;
    localparam logic [BYTE_W-1:0] CH_I     = 8'h69;
    localparam logic [BYTE_W-1:0] CH_L     = 8'h6C;
    localparam logic [BYTE_W-1:0] CH_D     = 8'h64;
    localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9     = 8'h39;

    typedef enum logic [5:0] {
        M_ITEM    = 6'b000001,
        M_STRLEN  = 6'b000010,
        M_STRDATA = 6'b000100,
        M_INT     = 6'b001000,
        M_DONE    = 6'b010000,
        M_ERROR   = 6'b100000
    } t_mode;

    // stack entry: bit 0 dict, bit 1 key expected
    logic [1:0]          mem [MAX_DEPTH];

    t_mode               r_mode, n_mode;
    logic [VALUE_W-1:0]  r_acc, n_acc;
    logic [VALUE_W-1:0]  r_rem, n_rem;
    logic [PTR_W-1:0]    r_ptr, n_ptr;
    logic                r_top_dict, n_top_dict;
    logic                r_top_key, n_top_key;
    logic [1:0]          r_below;

    logic                is_digit;
    logic [3:0]          dval;
    logic [VALUE_W-1:0]  acc10;
    logic                pop_dict, pop_key;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [1:0]          mem_wdata;
    logic [PTR_W-1:0]    rd_ptr;
    t_result             res;

    assign is_digit = (i_byte >= CH_0) && (i_byte <= CH_9);
    assign dval     = 4'(i_byte - CH_0);
    assign acc10    = {r_acc[VALUE_W-4:0], 3'b000} + {r_acc[VALUE_W-2:0], 1'b0}
                    + VALUE_W'(dval);

    assign pop_dict = (r_ptr == PTR_W'(1)) ? 1'b0 : r_below[0];
    assign pop_key  = (r_ptr == PTR_W'(1)) ? 1'b0 : r_below[1];

    always_comb begin
        n_mode     = r_mode;
        n_acc      = r_acc;
        n_rem      = r_rem;
        n_ptr      = r_ptr;
        n_top_dict = r_top_dict;
        n_top_key  = r_top_key;
        mem_we     = 1'b0;
        mem_wdata  = {r_top_key, r_top_dict};
        mem_waddr  = AW'(r_ptr - PTR_W'(1));
        res        = '0;
        res.ev     = EV_BUSY;

        case (r_mode)
            M_ITEM: begin
                if (is_digit) begin
                    n_acc  = VALUE_W'(dval);
                    n_mode = M_STRLEN;
                end else if (i_byte == CH_E) begin
                    if (r_ptr == '0) begin
                        n_mode = M_DONE;
                        res.ev = EV_END;
                    end else if (r_top_dict && !r_top_key) begin
                        n_mode = M_ERROR;
                        res.ev = EV_ERROR;
                    end else begin
                        n_ptr      = r_ptr - PTR_W'(1);
                        n_top_dict = pop_dict;
                        n_top_key  = pop_dict ? ~pop_key : pop_key;
                        res.ev     = EV_CLOSE;
                    end
                end else if (r_top_dict && r_top_key) begin
                    n_mode = M_ERROR;
                    res.ev = EV_ERROR;
                end else if (i_byte == CH_I) begin
                    n_acc  = '0;
                    n_mode = M_INT;
                end else if (i_byte == CH_L || i_byte == CH_D) begin
                    if (r_ptr >= PTR_W'(MAX_DEPTH)) begin
                        n_mode = M_ERROR;
                        res.ev = EV_ERROR;
                    end else begin
                        mem_we     = (r_ptr != '0);
                        n_ptr      = r_ptr + PTR_W'(1);
                        n_top_dict = (i_byte == CH_D);
                        n_top_key  = (i_byte == CH_D);
                        res.ev     = (i_byte == CH_D) ? EV_DICT : EV_LIST;
                    end
                end else begin
                    n_mode = M_ERROR;
                    res.ev = EV_ERROR;
                end
            end
            M_STRLEN: begin
                if (is_digit) begin
                    n_acc = acc10;
                end else if (i_byte == CH_COLON) begin
                    n_rem      = r_acc;
                    res.ev     = EV_STR_START;
                    res.value  = r_acc;
                    res.is_key = r_top_key;
                    if (r_acc == '0) begin
                        res.str_last = 1'b1;
                        n_mode       = M_ITEM;
                        if (r_top_dict) begin
                            n_top_key = ~r_top_key;
                        end
                    end else begin
                        n_mode = M_STRDATA;
                    end
                end else begin
                    n_mode = M_ERROR;
                    res.ev = EV_ERROR;
                end
            end
            M_STRDATA: begin
                res.ev        = EV_STR_BYTE;
                res.data_byte = i_byte;
                res.is_key    = r_top_key;
                n_rem         = r_rem - VALUE_W'(1);
                if (r_rem == VALUE_W'(1)) begin
                    res.str_last = 1'b1;
                    n_mode       = M_ITEM;
                    if (r_top_dict) begin
                        n_top_key = ~r_top_key;
                    end
                end
            end
            M_INT: begin
                if (is_digit) begin
                    n_acc = acc10;
                end else if (i_byte == CH_E) begin
                    res.ev    = EV_INT;
                    res.value = r_acc;
                    n_mode    = M_ITEM;
                    if (r_top_dict) begin
                        n_top_key = ~r_top_key;
                    end
                end else begin
                    n_mode = M_ERROR;
                    res.ev = EV_ERROR;
                end
            end
            M_DONE: begin
                res.ev = EV_END;
            end
            default: begin
                n_mode = M_ERROR;
                res.ev = EV_ERROR;
            end
        endcase

        res.depth = DEPTH_W'(n_ptr);
    end

    assign o_result = res;

    // prefetch the entry below the top of stack for the next byte
    assign rd_ptr    = i_accept ? n_ptr : r_ptr;
    assign mem_raddr = (rd_ptr >= PTR_W'(2)) ? AW'(rd_ptr - PTR_W'(2)) : '0;

    always_ff @(posedge i_clk) begin
        if (i_accept && mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (i_accept && mem_we && (mem_waddr == mem_raddr)) begin
            r_below <= mem_wdata;
        end else begin
            r_below <= mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_ITEM;
            r_acc      <= '0;
            r_rem      <= '0;
            r_ptr      <= '0;
            r_top_dict <= 1'b0;
            r_top_key  <= 1'b0;
        end else if (i_accept) begin
            r_mode     <= n_mode;
            r_acc      <= n_acc;
            r_rem      <= n_rem;
            r_ptr      <= n_ptr;
            r_top_dict <= n_top_dict;
            r_top_key  <= n_top_key;
        end
    end

endmodule

>>> design/bsp_out_buf.sv
// Result register with skid stage between the tokenizer core and the output stream.
// Depends on bsp_pkg.
module bsp_out_buf
    import bsp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_result,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;

    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_main_valid;
    assign o_result = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_valid) begin
            if (!r_main_valid || i_ready) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (i_ready) begin
            r_main_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_ready) begin
                r_main <= r_skid;
            end
        end else if (i_valid) begin
            if (!r_main_valid || i_ready) begin
                r_main <= i_result;
            end else begin
                r_skid <= i_result;
            end
        end
    end

endmodule

>>> design/bencode_stream_parser.sv
// Top level of the bencode stream parser: tokenizer core plus output buffer.
// Depends on bsp_pkg, bsp_core and bsp_out_buf.
//
// One byte in, one token event out. The parser takes a byte in every cycle while
// input is not held off and returns its event through a result register backed
// by a skid stage, so a stalled output holds at most two events before input is
// held off. Throughput is likewise one byte per cycle, set by the parse state, the
// times-ten accumulator and the cached stack top updating together per byte. The
// stack lives in a MAX_DEPTH-entry memory with no clearing pass; entries below the
// top are prefetched ahead of the next byte so consecutive closes run at full rate.
// Errors are sticky and a close at top level ends the stream; reset restarts it.
module bencode_stream_parser
    import bsp_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] byte_in
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [31:0] value, [39:32] data_byte, [45:40] depth
    output logic [4:0]  o_m_axis_tuser,   // [3:0] event_res, [4] is_key
    output logic        o_m_axis_tlast    // string_last
);

    logic    accept;
    t_result core_res;
    t_result out_res;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    bsp_core #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_axis_tdata),
        .o_result (core_res)
    );

    bsp_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_result (core_res),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (out_res)
    );

    assign o_m_axis_tdata = {2'b00, out_res.depth, out_res.data_byte, out_res.value};
    assign o_m_axis_tuser = {out_res.is_key, out_res.ev};
    assign o_m_axis_tlast = out_res.str_last;

endmodule
